// File: hw/rtl/dpf_pkg.sv
// ============================================================================
// dpf_pkg
// Types, constants and arithmetic helpers for the dipole pair force unit.
// Values inside the pipeline use a sign-magnitude format m * 2^e, with a
// 32-bit magnitude normalized to [2^31, 2^32), or zero.
// ============================================================================
package dpf_pkg;

    // One input item: positions and world-axis moments, signed Q8.24.
    typedef struct packed {
        logic signed [31:0] self_x;
        logic signed [31:0] self_y;
        logic signed [31:0] self_z;
        logic signed [31:0] self_mx;
        logic signed [31:0] self_my;
        logic signed [31:0] self_mz;
        logic signed [31:0] other_x;
        logic signed [31:0] other_y;
        logic signed [31:0] other_z;
        logic signed [31:0] other_mx;
        logic signed [31:0] other_my;
        logic signed [31:0] other_mz;
    } t_in;

    // One result item: force, torque and field in signed Q16.32.
    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic signed [47:0] torque_x;
        logic signed [47:0] torque_y;
        logic signed [47:0] torque_z;
        logic signed [47:0] field_x;
        logic signed [47:0] field_y;
        logic signed [47:0] field_z;
        logic               coincident;
    } t_out;

    typedef logic signed [11:0] t_exp;

    // Normalized sign-magnitude number.
    typedef struct packed {
        logic        neg;
        logic [31:0] m;
        t_exp        e;
    } t_pf;

    // Aligned sum before normalization.
    typedef struct packed {
        logic        neg;
        logic [63:0] v;
        t_exp        e;
    } t_raw;

    // Everything that travels down the pipeline with an item.
    typedef struct packed {
        logic             coin;
        t_pf [2:0]        d;
        t_pf [2:0]        m1;
        t_pf [2:0]        m2;
        t_pf [8:0]        pa;
        t_raw [8:0]       ra;
        t_pf              s;
        t_exp             ep;
        logic [63:0]      sq_x;
        logic [34:0]      sq_rem;
        logic [31:0]      sq_root;
        logic [31:0]      dv_r;
        logic [32:0]      dv_rem;
        logic [31:0]      dv_q;
        t_pf              inv;
        t_pf              inv2;
        t_pf              inv3;
        t_pf              inv4;
        t_pf              kf;
        t_pf              kb;
        t_pf [2:0]        u;
        t_pf              m1u;
        t_pf              m2u;
        t_pf              m1m2;
        t_pf              pp;
        t_pf              tm3;
        t_pf              c5;
        t_pf [2:0]        fa;
        t_raw [2:0]       fr;
        t_pf [2:0]        ba;
        t_raw [2:0]       br;
        t_pf [2:0]        tca;
        t_pf [2:0]        b;
        t_pf [2:0]        ta;
        t_pf [2:0]        tb;
        t_raw [2:0]       tr;
        t_pf [2:0]        fo;
        t_pf [2:0]        to;
    } t_ctx;

    // Operation done by one pipeline stage.
    typedef enum logic [4:0] {
        ST_DSQ, ST_ADD1, ST_NRM1, ST_ADD2, ST_NRM2, ST_SQ_INIT, ST_SQRT,
        ST_DIV_INIT, ST_DIV, ST_INV, ST_U, ST_PROD, ST_DOT_ADD1, ST_DOT_NRM1,
        ST_DOT_ADD2, ST_DOT_NRM2, ST_TERMS, ST_MIX, ST_SUM1, ST_SUM2, ST_SUM3,
        ST_SUM4, ST_FIN1, ST_FIN2
    } t_step;

    localparam int NSTAGE = 38;

    localparam t_step STEP_PLAN [NSTAGE] = '{
        ST_DSQ, ST_ADD1, ST_NRM1, ST_ADD2, ST_NRM2, ST_SQ_INIT,
        ST_SQRT, ST_SQRT, ST_SQRT, ST_SQRT, ST_SQRT, ST_SQRT, ST_SQRT, ST_SQRT,
        ST_DIV_INIT,
        ST_DIV, ST_DIV, ST_DIV, ST_DIV, ST_DIV, ST_DIV, ST_DIV, ST_DIV,
        ST_INV, ST_U, ST_PROD, ST_DOT_ADD1, ST_DOT_NRM1, ST_DOT_ADD2,
        ST_DOT_NRM2, ST_TERMS, ST_MIX, ST_SUM1, ST_SUM2, ST_SUM3, ST_SUM4,
        ST_FIN1, ST_FIN2
    };

    // Constants 3e-7, 1e-7, 5 and 3 in the internal format.
    localparam t_pf C_3E7 = '{neg: 1'b0, m: 32'd2702159776, e: -12'sd53};
    localparam t_pf C_1E7 = '{neg: 1'b0, m: 32'd3602879702, e: -12'sd55};
    localparam t_pf C_FIVE = '{neg: 1'b0, m: 32'hA000_0000, e: -12'sd29};
    localparam t_pf C_THREE = '{neg: 1'b0, m: 32'hC000_0000, e: -12'sd30};
    localparam t_pf PF_ZERO = '{neg: 1'b0, m: 32'd0, e: 12'sd0};

    localparam logic [47:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] OUT_MIN_MAG = 48'h8000_0000_0000;

    // Normalize so that the leading one lands on bit 31; dropped bits truncate.
    function automatic t_pf pf_norm(input logic neg, input logic [63:0] v,
                                    input t_exp e);
        t_pf r;
        int  p;
        r = PF_ZERO;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) p = i;
        end
        if (v != 64'd0) begin
            r.neg = neg;
            if (p >= 31) begin
                r.m = 32'(v >> (p - 31));
                r.e = e + t_exp'(p - 31);
            end else begin
                r.m = 32'(v << (31 - p));
                r.e = e - t_exp'(31 - p);
            end
        end
        return r;
    endfunction

    // Signed 33-bit integer scaled by 2^-24.
    function automatic t_pf pf_int33(input logic signed [32:0] v);
        logic [32:0] mag;
        mag = v[32] ? 33'(-v) : 33'(v);
        return pf_norm(v[32], {31'd0, mag}, -12'sd24);
    endfunction

    function automatic t_pf pf_mul(input t_pf a, input t_pf b);
        t_pf         r;
        logic [63:0] p;
        r = PF_ZERO;
        p = {32'd0, a.m} * {32'd0, b.m};
        if (a.m != 32'd0 && b.m != 32'd0) begin
            r.neg = a.neg ^ b.neg;
            if (p[63]) begin
                r.m = p[63:32];
                r.e = a.e + b.e + 12'sd32;
            end else begin
                r.m = p[62:31];
                r.e = a.e + b.e + 12'sd31;
            end
        end
        return r;
    endfunction

    function automatic t_pf pf_neg(input t_pf a);
        t_pf r;
        r = a;
        r.neg = (a.m != 32'd0) ? !a.neg : 1'b0;
        return r;
    endfunction

    // Align and add; the sum is normalized by pf_fin in the next stage.
    function automatic t_raw pf_add(input t_pf a, input t_pf b);
        t_raw               r;
        t_pf                hi;
        t_pf                lo;
        logic signed [12:0] gap;
        logic [63:0]        vh;
        logic [63:0]        vl;
        if (a.e >= b.e) begin
            hi = a;
            lo = b;
        end else begin
            hi = b;
            lo = a;
        end
        gap = {hi.e[11], hi.e} - {lo.e[11], lo.e};
        vh = {2'd0, hi.m, 30'd0};
        vl = (gap >= 13'sd64) ? 64'd0 : ({2'd0, lo.m, 30'd0} >> gap[5:0]);
        r.e = hi.e - 12'sd30;
        if (a.m == 32'd0) begin
            r = '{neg: b.neg, v: {2'd0, b.m, 30'd0}, e: b.e - 12'sd30};
        end else if (b.m == 32'd0) begin
            r = '{neg: a.neg, v: {2'd0, a.m, 30'd0}, e: a.e - 12'sd30};
        end else if (hi.neg == lo.neg) begin
            r.neg = hi.neg;
            r.v = vh + vl;
        end else if (vh >= vl) begin
            r.neg = hi.neg;
            r.v = vh - vl;
        end else begin
            r.neg = lo.neg;
            r.v = vl - vh;
        end
        return r;
    endfunction

    function automatic t_pf pf_fin(input t_raw r);
        return pf_norm(r.neg, r.v, r.e);
    endfunction

    // Convert to Q16.32 with truncation toward zero and saturation.
    function automatic logic [47:0] pf_out(input t_pf a);
        logic signed [12:0] sh;
        logic [47:0]        mag;
        logic [47:0]        r;
        sh = {a.e[11], a.e} + 13'sd32;
        if (sh >= 13'sd16) begin
            mag = OUT_MIN_MAG;
        end else if (sh >= 13'sd0) begin
            mag = {16'd0, a.m} << sh[3:0];
        end else if (sh <= -13'sd32) begin
            mag = 48'd0;
        end else begin
            mag = {16'd0, a.m >> 5'(-sh)};
        end
        if (a.m == 32'd0) begin
            r = 48'd0;
        end else if (a.neg) begin
            r = 48'd0 - mag;
        end else begin
            r = mag[47] ? OUT_MAX : mag;
        end
        return r;
    endfunction

    // First stage: separation vector, moments and the coincidence flag.
    function automatic t_ctx dpf_ingest(input t_in x);
        t_ctx               c;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        c = '0;
        dx = {x.self_x[31], x.self_x} - {x.other_x[31], x.other_x};
        dy = {x.self_y[31], x.self_y} - {x.other_y[31], x.other_y};
        dz = {x.self_z[31], x.self_z} - {x.other_z[31], x.other_z};
        c.coin = (dx == 33'sd0) && (dy == 33'sd0) && (dz == 33'sd0);
        c.d[0] = pf_int33(dx);
        c.d[1] = pf_int33(dy);
        c.d[2] = pf_int33(dz);
        c.m2[0] = pf_int33({x.self_mx[31], x.self_mx});
        c.m2[1] = pf_int33({x.self_my[31], x.self_my});
        c.m2[2] = pf_int33({x.self_mz[31], x.self_mz});
        c.m1[0] = pf_int33({x.other_mx[31], x.other_mx});
        c.m1[1] = pf_int33({x.other_my[31], x.other_my});
        c.m1[2] = pf_int33({x.other_mz[31], x.other_mz});
        return c;
    endfunction

    // Work of one pipeline stage.
    function automatic t_ctx dpf_step(input t_step step, input t_ctx c);
        t_ctx        n;
        logic [32:0] mm;
        logic [34:0] trial;
        n = c;
        unique case (step)
            ST_DSQ: begin
                for (int i = 0; i < 3; i++) n.pa[i] = pf_mul(c.d[i], c.d[i]);
            end
            ST_ADD1: n.ra[0] = pf_add(c.pa[0], c.pa[1]);
            ST_NRM1: n.pa[0] = pf_fin(c.ra[0]);
            ST_ADD2: n.ra[0] = pf_add(c.pa[0], c.pa[2]);
            ST_NRM2: n.s = pf_fin(c.ra[0]);
            ST_SQ_INIT: begin
                // Make the exponent even so the square root halves it exactly.
                mm = c.s.e[0] ? {c.s.m, 1'b0} : {1'b0, c.s.m};
                n.ep = c.s.e[0] ? (c.s.e - 12'sd1) : c.s.e;
                n.sq_x = {1'b0, mm, 30'd0};
                n.sq_rem = '0;
                n.sq_root = '0;
            end
            ST_SQRT: begin
                // Four result bits of the integer square root.
                for (int it = 0; it < 4; it++) begin
                    n.sq_rem = {n.sq_rem[32:0], n.sq_x[63:62]};
                    n.sq_x = {n.sq_x[61:0], 2'b00};
                    trial = {1'b0, n.sq_root, 2'b01};
                    if (n.sq_rem >= trial) begin
                        n.sq_rem = n.sq_rem - trial;
                        n.sq_root = {n.sq_root[30:0], 1'b1};
                    end else begin
                        n.sq_root = {n.sq_root[30:0], 1'b0};
                    end
                end
            end
            ST_DIV_INIT: begin
                n.dv_r = (c.sq_root == 32'd0) ? 32'd1 : c.sq_root;
                n.dv_rem = 33'h0_4000_0000;
                n.dv_q = '0;
            end
            ST_DIV: begin
                // Four quotient bits of 2^62 / root, restoring.
                for (int it = 0; it < 4; it++) begin
                    n.dv_rem = {n.dv_rem[31:0], 1'b0};
                    if (n.dv_rem >= {1'b0, n.dv_r}) begin
                        n.dv_rem = n.dv_rem - {1'b0, n.dv_r};
                        n.dv_q = {n.dv_q[30:0], 1'b1};
                    end else begin
                        n.dv_q = {n.dv_q[30:0], 1'b0};
                    end
                end
            end
            ST_INV: n.inv = pf_norm(1'b0, {32'd0, c.dv_q},
                                    12'sd15 - (c.ep >>> 1) - 12'sd62);
            ST_U: begin
                for (int i = 0; i < 3; i++) n.u[i] = pf_mul(c.d[i], c.inv);
                n.inv2 = pf_mul(c.inv, c.inv);
            end
            ST_PROD: begin
                n.inv3 = pf_mul(c.inv2, c.inv);
                n.inv4 = pf_mul(c.inv2, c.inv2);
                for (int i = 0; i < 3; i++) begin
                    n.pa[i] = pf_mul(c.m1[i], c.m2[i]);
                    n.pa[3 + i] = pf_mul(c.m1[i], c.u[i]);
                    n.pa[6 + i] = pf_mul(c.m2[i], c.u[i]);
                end
            end
            ST_DOT_ADD1: begin
                n.kf = pf_mul(C_3E7, c.inv4);
                n.kb = pf_mul(C_1E7, c.inv3);
                for (int k = 0; k < 3; k++) n.ra[3 * k] = pf_add(c.pa[3 * k], c.pa[3 * k + 1]);
            end
            ST_DOT_NRM1: begin
                for (int k = 0; k < 3; k++) n.pa[3 * k] = pf_fin(c.ra[3 * k]);
            end
            ST_DOT_ADD2: begin
                for (int k = 0; k < 3; k++) n.ra[3 * k] = pf_add(c.pa[3 * k], c.pa[3 * k + 2]);
            end
            ST_DOT_NRM2: begin
                n.m1m2 = pf_fin(c.ra[0]);
                n.m1u = pf_fin(c.ra[3]);
                n.m2u = pf_fin(c.ra[6]);
            end
            ST_TERMS: begin
                n.pp = pf_mul(c.m1u, c.m2u);
                n.tm3 = pf_mul(C_THREE, c.m1u);
                for (int i = 0; i < 3; i++) begin
                    n.fa[i] = pf_mul(c.m2[i], c.m1u);
                    n.pa[i] = pf_mul(c.m1[i], c.m2u);
                    n.pa[3 + i] = pf_mul(c.u[i], c.m1m2);
                end
            end
            ST_MIX: begin
                n.c5 = pf_mul(C_FIVE, c.pp);
                for (int i = 0; i < 3; i++) begin
                    n.ba[i] = pf_mul(c.tm3, c.u[i]);
                    n.fr[i] = pf_add(c.fa[i], c.pa[i]);
                end
            end
            ST_SUM1: begin
                for (int i = 0; i < 3; i++) begin
                    n.fa[i] = pf_fin(c.fr[i]);
                    n.tca[i] = pf_mul(c.u[i], c.c5);
                    n.br[i] = pf_add(c.ba[i], pf_neg(c.m1[i]));
                end
            end
            ST_SUM2: begin
                for (int i = 0; i < 3; i++) begin
                    n.fr[i] = pf_add(c.fa[i], c.pa[3 + i]);
                    n.ba[i] = pf_fin(c.br[i]);
                end
            end
            ST_SUM3: begin
                for (int i = 0; i < 3; i++) begin
                    n.fa[i] = pf_fin(c.fr[i]);
                    n.b[i] = pf_mul(c.kb, c.ba[i]);
                end
            end
            ST_SUM4: begin
                for (int i = 0; i < 3; i++) n.fr[i] = pf_add(c.fa[i], pf_neg(c.tca[i]));
                // Cross product terms of the acted-on moment with the field.
                n.ta[0] = pf_mul(c.m2[1], c.b[2]);
                n.tb[0] = pf_mul(c.m2[2], c.b[1]);
                n.ta[1] = pf_mul(c.m2[2], c.b[0]);
                n.tb[1] = pf_mul(c.m2[0], c.b[2]);
                n.ta[2] = pf_mul(c.m2[0], c.b[1]);
                n.tb[2] = pf_mul(c.m2[1], c.b[0]);
            end
            ST_FIN1: begin
                for (int i = 0; i < 3; i++) begin
                    n.fa[i] = pf_fin(c.fr[i]);
                    n.tr[i] = pf_add(c.ta[i], pf_neg(c.tb[i]));
                end
            end
            ST_FIN2: begin
                for (int i = 0; i < 3; i++) begin
                    n.fo[i] = pf_mul(c.kf, c.fa[i]);
                    n.to[i] = pf_fin(c.tr[i]);
                end
            end
            default: n = c;
        endcase
        return n;
    endfunction

    // Last stage: fixed-point conversion, zeros for coincident positions.
    function automatic t_out dpf_result(input t_ctx c);
        t_out r;
        r = '0;
        r.coincident = c.coin;
        if (!c.coin) begin
            r.force_x = pf_out(c.fo[0]);
            r.force_y = pf_out(c.fo[1]);
            r.force_z = pf_out(c.fo[2]);
            r.torque_x = pf_out(c.to[0]);
            r.torque_y = pf_out(c.to[1]);
            r.torque_z = pf_out(c.to[2]);
            r.field_x = pf_out(c.b[0]);
            r.field_y = pf_out(c.b[1]);
            r.field_z = pf_out(c.b[2]);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/dipole_pair_force_torque_field.sv
// ============================================================================
// dipole_pair_force_torque_field
// Dipole-dipole force, torque and source field for one magnet pair per item.
// ============================================================================
// Channel | Direction | Handshake                   | Payload
// in      | input     | i_in_valid / o_in_stall     | i_in_item  (t_in)
// out     | output    | o_out_valid / i_out_stall   | o_out_item (t_out)
//
// An item can enter every cycle while no stall holds the ingest stage.
// The depth is 40 register stages: the ingest register, 38 arithmetic stages
// (eight of square root and eight of division, four bits each, among them)
// and the output register.
// Reset clears only the valid bits; no clearing pass is needed.
// A stall holds only the stages that are full behind it; bubbles close up.
// ============================================================================
module dipole_pair_force_torque_field import dpf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_item
);

    logic             v   [NSTAGE + 1];
    t_ctx             c   [NSTAGE + 1];
    logic             adv [NSTAGE + 2];
    logic             r_in_valid;
    t_ctx             r_in_ctx;
    logic             r_out_valid;
    t_out             r_out_item;

    // Ingest stage.
    assign adv[0]     = !r_in_valid || adv[1];
    assign o_in_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv[0]) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_in_ctx <= dpf_ingest(i_in_item);
        end
    end

    assign v[0] = r_in_valid;
    assign c[0] = r_in_ctx;

    // Arithmetic stages.
    for (genvar g = 1; g <= NSTAGE; g++) begin : g_stage
        dpf_stage #(
            .STEP (STEP_PLAN[g - 1])
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g - 1]),
            .i_ctx   (c[g - 1]),
            .i_adv   (adv[g + 1]),
            .o_adv   (adv[g]),
            .o_valid (v[g]),
            .o_ctx   (c[g])
        );
    end

    // Output register.
    assign adv[NSTAGE + 1] = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv[NSTAGE + 1]) begin
            r_out_valid <= v[NSTAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[NSTAGE + 1]) begin
            r_out_item <= dpf_result(c[NSTAGE]);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: hw/rtl/dpf_stage.sv
// ============================================================================
// dpf_stage
// One register stage of the pipeline: applies its step to the item context
// and holds the item while the next stage is full and stalled.
// ============================================================================
module dpf_stage import dpf_pkg::*; #(
    parameter t_step STEP = ST_DSQ
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_ctx i_ctx,
    input  logic i_adv,
    output logic o_adv,
    output logic o_valid,
    output t_ctx o_ctx
);

    logic r_valid;
    t_ctx r_ctx;

    // The stage can load when empty or when its item moves on.
    assign o_adv = !r_valid || i_adv;

    // Valid bit with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    // Item context.
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_ctx <= dpf_step(STEP, i_ctx);
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the dipole pair force, torque and field unit.
// A directed table covers coincident positions, extreme separations and
// moments, and saturation. Random magnet pairs follow. Every result is
// compared with a table entry or an in-bench sign-magnitude predictor while
// both handshakes idle and stall at random outside a quiet stretch.
// ============================================================================
module tb import dpf_pkg::*;;

    localparam int IDLE_PCT    = 37;
    localparam int RANDOM_N    = 1780;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 400000;

    // Sign-magnitude number m * 2^e used by the predictor.
    typedef struct {
        bit          neg;
        bit [31:0]   m;
        int          e;
    } t_fnum;

    // One row of the directed table.
    typedef struct {
        t_in  pair;
        bit   known;
        t_out result;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_item;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_item;

    t_out pending_results[$];
    int   fail_count = 0;
    int   cycle_count = 0;
    bit   quiet;

    dipole_pair_force_torque_field dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor arithmetic.
    // ------------------------------------------------------------------------

    // Bring the leading one to bit 31, truncating dropped bits.
    function automatic t_fnum fn_normalize(bit neg, bit [63:0] v, int e);
        t_fnum r;
        r = '{0, 0, 0};
        if (v != 0) begin
            while (v >= 64'h1_0000_0000) begin
                v = v >> 1;
                e++;
            end
            while (v < 64'h8000_0000) begin
                v = v << 1;
                e--;
            end
            r = '{neg, v[31:0], e};
        end
        return r;
    endfunction

    function automatic t_fnum fn_from_int(longint v, int e);
        if (v < 0) return fn_normalize(1'b1, 64'(-v), e);
        return fn_normalize(1'b0, 64'(v), e);
    endfunction

    function automatic t_fnum fn_times(t_fnum a, t_fnum b);
        return fn_normalize(a.neg ^ b.neg, 64'(a.m) * 64'(b.m), a.e + b.e);
    endfunction

    function automatic t_fnum fn_negate(t_fnum a);
        a.neg = (a.m != 0) ? !a.neg : 1'b0;
        return a;
    endfunction

    function automatic t_fnum fn_plus(t_fnum a, t_fnum b);
        t_fnum     hi;
        t_fnum     lo;
        bit [63:0] vh;
        bit [63:0] vl;
        int        gap;
        if (a.m == 0) return b;
        if (b.m == 0) return a;
        if (a.e >= b.e) begin
            hi = a;
            lo = b;
        end else begin
            hi = b;
            lo = a;
        end
        gap = hi.e - lo.e;
        vh = 64'(hi.m) << 30;
        vl = (gap >= 64) ? 64'd0 : ((64'(lo.m) << 30) >> gap);
        if (hi.neg == lo.neg) return fn_normalize(hi.neg, vh + vl, hi.e - 30);
        if (vh >= vl) return fn_normalize(hi.neg, vh - vl, hi.e - 30);
        return fn_normalize(lo.neg, vl - vh, hi.e - 30);
    endfunction

    function automatic t_fnum fn_dot(t_fnum a[3], t_fnum b[3]);
        return fn_plus(fn_plus(fn_times(a[0], b[0]), fn_times(a[1], b[1])),
                       fn_times(a[2], b[2]));
    endfunction

    // Reciprocal square root through an integer root and a division.
    function automatic t_fnum fn_recip_root(t_fnum s);
        bit [63:0] x;
        bit [63:0] root;
        bit [63:0] probe;
        bit [63:0] quot;
        bit [63:0] mm;
        int        ep;
        mm = 64'(s.m);
        ep = s.e;
        if (s.e % 2 != 0) begin
            mm = mm << 1;
            ep = s.e - 1;
        end
        x = mm << 30;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > x) probe = probe >> 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x = x - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        if (root == 0) root = 1;
        quot = (64'd1 << 62) / root;
        return fn_normalize(1'b0, quot, 15 - ep / 2 - 62);
    endfunction

    // Convert to Q16.32, truncating toward zero and saturating.
    function automatic logic [47:0] fn_to_fixed(t_fnum a);
        bit [63:0] mag;
        int        sh;
        sh = a.e + 32;
        if (a.m == 0) return 48'd0;
        if (sh >= 16) mag = 64'h8000_0000_0000;
        else if (sh >= 0) mag = 64'(a.m) << sh;
        else if (sh <= -32) mag = 0;
        else mag = 64'(a.m) >> (-sh);
        if (a.neg) begin
            if (mag > 64'h8000_0000_0000) mag = 64'h8000_0000_0000;
            return 48'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF_FFFF) mag = 64'h7FFF_FFFF_FFFF;
        return mag[47:0];
    endfunction

    // Force, torque and field for one magnet pair.
    function automatic t_out predict_pair(t_in p);
        t_out   r;
        longint sep[3];
        t_fnum  d[3];
        t_fnum  src[3];
        t_fnum  dst[3];
        t_fnum  u[3];
        t_fnum  fld[3];
        t_fnum  inv;
        t_fnum  inv2;
        t_fnum  inv3;
        t_fnum  inv4;
        t_fnum  kf;
        t_fnum  kb;
        t_fnum  src_u;
        t_fnum  dst_u;
        t_fnum  src_dst;
        t_fnum  c5;
        t_fnum  t;
        t_fnum  k3e7;
        t_fnum  k1e7;
        t_fnum  tq[3];
        r = '0;
        k3e7 = '{0, 32'd2702159776, -53};
        k1e7 = '{0, 32'd3602879702, -55};
        sep[0] = longint'(p.self_x) - longint'(p.other_x);
        sep[1] = longint'(p.self_y) - longint'(p.other_y);
        sep[2] = longint'(p.self_z) - longint'(p.other_z);
        dst[0] = fn_from_int(longint'(p.self_mx), -24);
        dst[1] = fn_from_int(longint'(p.self_my), -24);
        dst[2] = fn_from_int(longint'(p.self_mz), -24);
        src[0] = fn_from_int(longint'(p.other_mx), -24);
        src[1] = fn_from_int(longint'(p.other_my), -24);
        src[2] = fn_from_int(longint'(p.other_mz), -24);
        for (int i = 0; i < 3; i++) d[i] = fn_from_int(sep[i], -24);
        if (sep[0] == 0 && sep[1] == 0 && sep[2] == 0) begin
            r.coincident = 1'b1;
            return r;
        end
        inv = fn_recip_root(fn_dot(d, d));
        for (int i = 0; i < 3; i++) u[i] = fn_times(d[i], inv);
        inv2 = fn_times(inv, inv);
        inv3 = fn_times(inv2, inv);
        inv4 = fn_times(inv2, inv2);
        kf = fn_times(k3e7, inv4);
        kb = fn_times(k1e7, inv3);
        src_u = fn_dot(src, u);
        dst_u = fn_dot(dst, u);
        src_dst = fn_dot(src, dst);
        c5 = fn_times(fn_from_int(5, 0), fn_times(src_u, dst_u));
        for (int i = 0; i < 3; i++) begin
            t = fn_plus(fn_plus(fn_plus(fn_times(dst[i], src_u), fn_times(src[i], dst_u)),
                                fn_times(u[i], src_dst)),
                        fn_negate(fn_times(u[i], c5)));
            unique case (i)
                0: r.force_x = fn_to_fixed(fn_times(kf, t));
                1: r.force_y = fn_to_fixed(fn_times(kf, t));
                default: r.force_z = fn_to_fixed(fn_times(kf, t));
            endcase
            fld[i] = fn_times(kb, fn_plus(fn_times(fn_times(fn_from_int(3, 0), src_u), u[i]),
                                          fn_negate(src[i])));
        end
        // Torque is the acted-on moment crossed with the unsaturated field.
        for (int i = 0; i < 3; i++) begin
            tq[i] = fn_plus(fn_times(dst[(i + 1) % 3], fld[(i + 2) % 3]),
                            fn_negate(fn_times(dst[(i + 2) % 3], fld[(i + 1) % 3])));
        end
        r.torque_x = fn_to_fixed(tq[0]);
        r.torque_y = fn_to_fixed(tq[1]);
        r.torque_z = fn_to_fixed(tq[2]);
        r.field_x = fn_to_fixed(fld[0]);
        r.field_y = fn_to_fixed(fld[1]);
        r.field_z = fn_to_fixed(fld[2]);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    function automatic logic [31:0] small_value(int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Random pair: mostly realistic geometry, with full-range, coincident,
    // nearly coincident and single-axis pairs mixed in.
    function automatic t_in random_pair();
        t_in p;
        int  mode;
        mode = $urandom_range(0, 9);
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (mode <= 5) begin
            p.self_x = small_value(1 << 25);
            p.self_y = small_value(1 << 25);
            p.self_z = small_value(1 << 25);
            p.other_x = small_value(1 << 25);
            p.other_y = small_value(1 << 25);
            p.other_z = small_value(1 << 25);
            p.self_mx = small_value(1 << 24);
            p.self_my = small_value(1 << 24);
            p.self_mz = small_value(1 << 24);
            p.other_mx = small_value(1 << 24);
            p.other_my = small_value(1 << 24);
            p.other_mz = small_value(1 << 24);
        end else if (mode == 7) begin
            p.other_x = p.self_x;
            p.other_y = p.self_y;
            p.other_z = p.self_z;
        end else if (mode == 8) begin
            p.other_x = p.self_x + small_value(2);
            p.other_y = p.self_y + small_value(2);
            p.other_z = p.self_z + small_value(2);
        end else if (mode == 9) begin
            p.other_y = p.self_y;
            p.other_z = p.self_z;
        end
        return p;
    endfunction

    // Offer one item, idling at random first, and record its result.
    task automatic send_pair(t_in p, bit known, t_out result);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= p;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(known ? result : predict_pair(p));
    endtask

    task automatic compare_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking and receiver stalls.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("force_x", want.force_x, o_out_item.force_x);
                    compare_field("force_y", want.force_y, o_out_item.force_y);
                    compare_field("force_z", want.force_z, o_out_item.force_z);
                    compare_field("torque_x", want.torque_x, o_out_item.torque_x);
                    compare_field("torque_y", want.torque_y, o_out_item.torque_y);
                    compare_field("torque_z", want.torque_z, o_out_item.torque_z);
                    compare_field("field_x", want.field_x, o_out_item.field_x);
                    compare_field("field_y", want.field_y, o_out_item.field_y);
                    compare_field("field_z", want.field_z, o_out_item.field_z);
                    compare_field("coincident", 48'(want.coincident),
                                  48'(o_out_item.coincident));
                end
            end
            i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        t_row rows[$];
        t_row row;
        t_out none;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        quiet = 1'b0;
        none = '0;

        // Coincident positions give zeros and the flag.
        row.known = 1'b1;
        row.result = '0;
        row.result.coincident = 1'b1;
        row.pair = '0;
        rows.push_back(row);
        row.pair = {12{32'h7FFF_FFFF}};
        rows.push_back(row);
        row.pair = {12{32'h8000_0000}};
        rows.push_back(row);

        // Everything else goes through the predictor.
        row.known = 1'b0;
        row.result = '0;
        // Widest separation on every axis with extreme moments.
        row.pair = {{3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}},
                    {3{32'h8000_0000}}, {3{32'h8000_0000}}};
        rows.push_back(row);
        row.pair = {{3{32'h8000_0000}}, {3{32'h8000_0000}},
                    {3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}}};
        rows.push_back(row);
        // One meter along each axis with unit moments.
        row.pair = '0;
        row.pair.self_x = 32'h0100_0000;
        row.pair.self_mx = 32'h0100_0000;
        row.pair.other_mx = 32'h0100_0000;
        rows.push_back(row);
        row.pair = '0;
        row.pair.self_y = 32'h0100_0000;
        row.pair.self_mz = 32'h0100_0000;
        row.pair.other_my = 32'h0100_0000;
        rows.push_back(row);
        row.pair = '0;
        row.pair.other_z = 32'h0100_0000;
        row.pair.self_my = 32'hFF00_0000;
        row.pair.other_mz = 32'h0100_0000;
        rows.push_back(row);
        // One LSB apart: most outputs saturate.
        row.pair = {{3{32'h0000_0000}}, {3{32'h7FFF_FFFF}},
                    32'h0000_0001, {2{32'h0000_0000}}, {3{32'h8000_0000}}};
        rows.push_back(row);
        row.pair = {{3{32'h1234_5678}}, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                    32'h1234_5679, 32'h1234_5677, 32'h1234_5678,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        rows.push_back(row);
        // Zero moments on one side.
        row.pair = '0;
        row.pair.self_x = 32'h0080_0000;
        row.pair.other_mx = 32'h7FFF_FFFF;
        rows.push_back(row);
        // Smallest moments far apart: results round to zero.
        row.pair = {{3{32'h7FFF_FFFF}}, {3{32'h0000_0001}},
                    {3{32'h8000_0000}}, {3{32'hFFFF_FFFF}}};
        rows.push_back(row);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) send_pair(rows[n].pair, rows[n].known, rows[n].result);

        // Let the pipe drain completely before the random part.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        for (int n = 0; n < RANDOM_N; n++) begin
            quiet = (n >= 700 && n < 1000);
            send_pair(random_pair(), 1'b0, none);
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
